### design/mrfr_pkg.sv
package mrfr_pkg;

  // Counter width covers the longest read reply (3 + 255 + 2 bytes)
  localparam int unsigned CNT_W = 9;

  // Frame lengths
  localparam logic [CNT_W-1:0] HDR_READ_LEN    = 9'd3;
  localparam logic [CNT_W-1:0] CRC_LEN         = 9'd2;
  localparam logic [CNT_W-1:0] WRITE_FRAME_LEN = 9'd8;
  localparam logic [CNT_W-1:0] FUNC_POS        = 9'd2;

  // Modbus CRC-16: reflected polynomial, start value
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic CFG_IDX_READ_FC  = 1'b0;
  localparam logic CFG_IDX_WRITE_FC = 1'b1;

  // Reset values of the function code registers
  localparam logic [7:0] READ_FC_RST  = 8'd3;
  localparam logic [7:0] WRITE_FC_RST = 8'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       response_pending;
    logic       chunk_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_address;
    logic [7:0] function_code;
    logic [7:0] data_byte_count;
    logic       crc_ok;
    logic       was_response;
  } out_word_t;

  // Handshake between the frame core and the result register
  typedef struct packed {
    logic take;   // core consumes the staged word this cycle
    logic load;   // the consumed word completes a frame
  } core_ctl_t;

  // One byte through the bitwise CRC-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/mrfr_in_reg.sv
module mrfr_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrfr_pkg::in_word_t in_data,
  input  logic              take,
  output logic              stg_valid,
  output mrfr_pkg::in_word_t stg_data
);
  import mrfr_pkg::*;

  logic     valid_r, valid_nxt;
  in_word_t data_r;

  // Free when empty or when the staged word leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign stg_valid = valid_r;
  assign stg_data  = data_r;

endmodule

### design/mrfr_core.sv
module mrfr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               stg_valid,
  input  mrfr_pkg::in_word_t  stg_data,
  input  logic               res_free,
  output mrfr_pkg::core_ctl_t ctl,
  output mrfr_pkg::out_word_t res_data
);
  import mrfr_pkg::*;

  logic [7:0]       read_fc_r, write_fc_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;

  logic [CNT_W-1:0] total;
  logic             is_read, is_write, known, emit, drop, take;

  // Function code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_fc_r  <= READ_FC_RST;
      write_fc_r <= WRITE_FC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_READ_FC:  read_fc_r  <= cfg_wdata;
        CFG_IDX_WRITE_FC: write_fc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign take = stg_valid && res_free;

  // Capture header bytes, run CRC, classify the frame
  always_comb begin
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    count_nxt = count_r;
    case (cnt_r)
      9'd0:    addr_nxt  = stg_data.rx_byte;
      9'd1:    func_nxt  = stg_data.rx_byte;
      9'd2:    count_nxt = stg_data.rx_byte;
      default: ;
    endcase
    crc_nxt = crc16_byte(crc_r, stg_data.rx_byte);
    cnt_nxt = cnt_r + 9'd1;

    // read format wins when both codes match
    is_read  = (func_nxt == read_fc_r);
    is_write = !is_read && (func_nxt == write_fc_r);
    total    = is_read ? (HDR_READ_LEN + {1'b0, count_nxt} + CRC_LEN) : WRITE_FRAME_LEN;
    known    = is_write || (cnt_nxt >= HDR_READ_LEN);

    emit = 1'b0;
    drop = 1'b0;
    if (cnt_nxt >= FUNC_POS) begin
      if (is_read || is_write) begin
        emit = known && (cnt_nxt == total);
        drop = known && (cnt_nxt > total);
      end else begin
        drop = 1'b1;
      end
    end
    // partial frame dies at chunk end unless a reply is awaited
    if (stg_data.chunk_last && !stg_data.response_pending) begin
      drop = 1'b1;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      addr_r  <= '0;
      func_r  <= '0;
      count_r <= '0;
      crc_r   <= CRC_INIT;
    end else if (take) begin
      if (emit || drop) begin
        cnt_r   <= '0;
        addr_r  <= '0;
        func_r  <= '0;
        count_r <= '0;
        crc_r   <= CRC_INIT;
      end else begin
        cnt_r   <= cnt_nxt;
        addr_r  <= addr_nxt;
        func_r  <= func_nxt;
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  assign ctl.take = take;
  assign ctl.load = take && emit;

  assign res_data.frame_address   = addr_nxt;
  assign res_data.function_code   = func_nxt;
  assign res_data.data_byte_count = is_read ? count_nxt : 8'd0;
  assign res_data.crc_ok          = (crc_nxt == 16'd0);
  assign res_data.was_response    = stg_data.response_pending;

endmodule

### design/mrfr_out_reg.sv
module mrfr_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  mrfr_pkg::core_ctl_t ctl,
  input  mrfr_pkg::out_word_t res_data,
  output logic                res_free,
  output logic                out_valid,
  input  logic                out_ready,
  output mrfr_pkg::out_word_t out_data
);
  import mrfr_pkg::*;

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  // Slot is free when empty or being drained this cycle
  assign res_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= res_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### design/modbus_rtu_frame_receiver_unit.sv
// Modbus RTU reply deframer: takes one received byte per word on the input channel
// and emits one result word per completed frame (address, function, byte count, CRC
// check, and whether a request was pending). A byte is taken every cycle unless an
// untaken result stalls input; each byte is registered in the input register, and
// the frame state and CRC-16 update are done in a single pass from there into the
// result register, which loads once its slot is free. A result that is not taken
// holds the result register, and the input register then holds one more byte before
// input stalls. The user must write the function code registers through the cfg port
// only while the block is idle (not enforced by the block); no clearing pass follows reset.
module modbus_rtu_frame_receiver_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrfr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrfr_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import mrfr_pkg::*;

  logic      stg_valid;
  in_word_t  stg_data;
  logic      res_free;
  core_ctl_t ctl;
  out_word_t res_data;

  // Input register
  mrfr_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .take      (ctl.take),
    .stg_valid (stg_valid),
    .stg_data  (stg_data)
  );

  // Frame state and CRC
  mrfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stg_valid (stg_valid),
    .stg_data  (stg_data),
    .res_free  (res_free),
    .ctl       (ctl),
    .res_data  (res_data)
  );

  // Result register
  mrfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res_data  (res_data),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/mrfr_checker.sv
module mrfr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mrfr_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mrfr_pkg::out_word_t out_data
);
  import mrfr_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With no result waiting, the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A byte word offered and not taken stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("offered byte word changed or withdrawn");

  // Stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

endmodule

bind modbus_rtu_frame_receiver_unit mrfr_checker u_mrfr_checker (.*);
